[design/keyed_stack_with_removal_top_macros.svh]
// Assertion macros for the keyed stack top level.
// Depends on a clock named clk and a reset named rst in the including scope.
`ifndef KEYED_STACK_WITH_REMOVAL_TOP_MACROS_SVH
`define KEYED_STACK_WITH_REMOVAL_TOP_MACROS_SVH

// same-cycle implication
`define KSR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define KSR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/ksr_pkg.sv]
// Shared types and constants for the keyed stack with removal.
// No dependencies.
`timescale 1ns / 1ps

package ksr_pkg;

  localparam int DEPTH        = 64;
  localparam int PAYLOAD_BITS = 64;
  localparam int KEY_BITS     = 16;
  localparam int CNT_W        = $clog2(DEPTH + 1);
  localparam int ADDR_W       = $clog2(DEPTH);

  typedef enum logic [1:0] {
    OP_PUSH   = 2'd0,
    OP_POP    = 2'd1,
    OP_REMOVE = 2'd2,
    OP_QUERY  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_MISS  = 2'd3
  } status_t;

  typedef struct packed {
    logic [KEY_BITS-1:0]     key;
    logic [PAYLOAD_BITS-1:0] pay;
  } rec_t;

  typedef struct packed {
    status_t                 status;
    logic [KEY_BITS-1:0]     key;
    logic [PAYLOAD_BITS-1:0] pay;
    logic [CNT_W-1:0]        count;
  } result_t;

endpackage

[design/ksr_ram.sv]
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`timescale 1ns / 1ps

module ksr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[design/ksr_engine.sv]
// Operation sequencer: push, pop, keyed scan and gap-closing shift over the record RAM.
// Depends on ksr_pkg.
`timescale 1ns / 1ps

module ksr_engine import ksr_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  op_t                     in_op,
  input  logic [KEY_BITS-1:0]     in_key,
  input  logic [PAYLOAD_BITS-1:0] in_pay,
  output logic                    res_valid,
  input  logic                    res_ready,
  output result_t                 res,
  output logic                    ram_we,
  output logic [ADDR_W-1:0]       ram_waddr,
  output rec_t                    ram_wdata,
  output logic                    ram_re,
  output logic [ADDR_W-1:0]       ram_raddr,
  input  rec_t                    ram_rdata
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_POP   = 5'b00010,
    S_SCAN  = 5'b00100,
    S_SHIFT = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  state_t                  state, state_next;
  op_t                     op, op_next;
  logic [KEY_BITS-1:0]     key, key_next;
  logic [CNT_W-1:0]        count, count_next;
  logic [CNT_W-1:0]        ptr, ptr_next;     // next entry to read
  status_t                 rstatus, rstatus_next;
  logic [KEY_BITS-1:0]     rkey, rkey_next;
  logic [PAYLOAD_BITS-1:0] rpay, rpay_next;

  logic [CNT_W-1:0] cnt_dec;
  logic [CNT_W-1:0] ptr_inc;
  logic [CNT_W-1:0] ptr_m2;

  assign cnt_dec = count - CNT_W'(1);
  assign ptr_inc = ptr + CNT_W'(1);
  assign ptr_m2  = ptr - CNT_W'(2);

  assign in_ready  = (state == S_IDLE);
  assign res_valid = (state == S_DONE);
  assign res       = '{status: rstatus, key: rkey, pay: rpay, count: count};

  always_comb begin
    state_next   = state;
    op_next      = op;
    key_next     = key;
    count_next   = count;
    ptr_next     = ptr;
    rstatus_next = rstatus;
    rkey_next    = rkey;
    rpay_next    = rpay;
    ram_we       = 1'b0;
    ram_waddr    = ptr_m2[ADDR_W-1:0];
    ram_wdata    = ram_rdata;
    ram_re       = 1'b0;
    ram_raddr    = ptr[ADDR_W-1:0];

    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          op_next      = in_op;
          key_next     = in_key;
          rstatus_next = ST_OK;
          rkey_next    = '0;
          rpay_next    = '0;
          unique case (in_op)
            OP_PUSH: begin
              state_next = S_DONE;
              if (count == CNT_W'(DEPTH)) begin
                rstatus_next = ST_FULL;
              end else begin
                ram_we     = 1'b1;
                ram_waddr  = count[ADDR_W-1:0];
                ram_wdata  = '{key: in_key, pay: in_pay};
                count_next = CNT_W'(count + CNT_W'(1));
              end
            end
            OP_POP: begin
              if (count == '0) begin
                rstatus_next = ST_EMPTY;
                state_next   = S_DONE;
              end else begin
                ram_re     = 1'b1;
                ram_raddr  = cnt_dec[ADDR_W-1:0];
                state_next = S_POP;
              end
            end
            OP_REMOVE, OP_QUERY: begin
              if (count == '0) begin
                rstatus_next = ST_MISS;
                state_next   = S_DONE;
              end else begin
                ram_re     = 1'b1;
                ram_raddr  = '0;
                ptr_next   = CNT_W'(1);
                state_next = S_SCAN;
              end
            end
          endcase
        end
      end

      S_POP: begin
        rkey_next  = ram_rdata.key;
        rpay_next  = ram_rdata.pay;
        count_next = cnt_dec;
        state_next = S_DONE;
      end

      // entry ptr-1 is on the read port
      S_SCAN: begin
        if (ram_rdata.key == key) begin
          rkey_next = ram_rdata.key;
          rpay_next = ram_rdata.pay;
          if (op == OP_REMOVE) begin
            if (ptr < count) begin
              ram_re     = 1'b1;
              ptr_next   = ptr_inc;
              state_next = S_SHIFT;
            end else begin
              count_next = cnt_dec;
              state_next = S_DONE;
            end
          end else begin
            state_next = S_DONE;
          end
        end else if (ptr < count) begin
          ram_re   = 1'b1;
          ptr_next = ptr_inc;
        end else begin
          rstatus_next = ST_MISS;
          state_next   = S_DONE;
        end
      end

      // entry ptr-1 arrives, lands at ptr-2; write trails read by two entries
      S_SHIFT: begin
        ram_we = 1'b1;
        if (ptr < count) begin
          ram_re   = 1'b1;
          ptr_next = ptr_inc;
        end else begin
          count_next = cnt_dec;
          state_next = S_DONE;
        end
      end

      S_DONE: begin
        if (res_ready) begin
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    op      <= op_next;
    key     <= key_next;
    ptr     <= ptr_next;
    rstatus <= rstatus_next;
    rkey    <= rkey_next;
    rpay    <= rpay_next;
  end

endmodule

[design/keyed_stack_with_removal_top.sv]
// Top level of the keyed LIFO stack with remove- and query-by-key.
// Depends on ksr_pkg, ksr_ram, ksr_engine and keyed_stack_with_removal_top_macros.svh.
`timescale 1ns / 1ps
`include "keyed_stack_with_removal_top_macros.svh"

// Usage:
//   Slave channel s_axis_* takes one command item: tuser is the operation
//   (push, pop, remove by key, query by key), tdata the key and payload.
//   Master channel m_axis_* returns exactly one result item per command:
//   tuser is the status, tdata the record found and the occupancy after it.
//   Records live in one 64 x 80-bit RAM with a registered read.
//   Query and remove scan from the oldest record to the match; remove then
//   shifts the later entries down at one entry per cycle to close the gap.
//   One command is worked at a time; the RAM ports pace scan and shift.
//   The result sits in an output register, so the next command is taken
//   while a finished result waits; a stalled receiver only holds the engine
//   once a second result is ready.
//   Reset (rst, synchronous, active high) empties the stack; RAM contents
//   are not cleared, entries above the count are never read.
module keyed_stack_with_removal_top import ksr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [79:0] s_axis_tdata,   // search_key[15:0], entry_payload[79:16]
  input  logic [1:0]  s_axis_tuser,   // operation[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [95:0] m_axis_tdata,   // out_key[15:0], out_payload[79:16],
                                      // entry_count[86:80], is_empty[87],
                                      // is_full[88], zero pad[95:89]
  output logic [1:0]  m_axis_tuser    // status[1:0]
);

  logic      ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  rec_t      ram_wdata;
  logic      ram_re;
  logic [ADDR_W-1:0] ram_raddr;
  rec_t      ram_rdata;

  logic      res_valid;
  logic      res_ready;
  result_t   res;

  // output register
  logic      out_valid;
  result_t   out_res;
  logic      out_empty;
  logic      out_full;

  ksr_ram #(
    .WIDTH ($bits(rec_t)),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  ksr_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_op     (op_t'(s_axis_tuser)),
    .in_key    (s_axis_tdata[15:0]),
    .in_pay    (s_axis_tdata[16 +: PAYLOAD_BITS]),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  // slot is free when empty or being drained this cycle
  assign res_ready = !out_valid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_res <= res;
    end
  end

  assign out_empty = (out_res.count == '0);
  assign out_full  = (out_res.count == CNT_W'(DEPTH));

  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = out_res.status;
  assign m_axis_tdata  = {7'b0, out_full, out_empty, 7'(out_res.count),
                          64'(out_res.pay), out_res.key};

  // ---- checks ----
  `KSR_ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready, "engine took a command but stayed idle")
  `KSR_ASSERT_NOW(a_no_result_when_idle, res_valid, !s_axis_tready, "result offered while accepting a command")
  `KSR_ASSERT_NOW(a_full_status, out_valid && out_res.status == ST_FULL, out_full, "full status without full count")
  `KSR_ASSERT_NOW(a_empty_status, out_valid && out_res.status == ST_EMPTY, out_empty, "empty status with records stored")

endmodule

[test/tb.sv]
// Self-checking testbench for keyed_stack_with_removal_top: push, pop, remove and query
// items against a behavioral stack with random stalls on both streams.
// Depends on ksr_pkg and the design sources only.
`timescale 1ns / 1ps

module tb;
  import ksr_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;  // cycles with no item moving on either side
  localparam int SETTLE_CYCLES  = 80;    // settle wait, longer than the longest scan/shift
  localparam int REPORT_MAX     = 10;

  // one command as the sender drives it
  typedef struct packed {
    op_t                 op;
    logic [KEY_BITS-1:0] key;
    logic [63:0]         pay;
  } command_t;

  // one result as the stack should return it
  typedef struct packed {
    status_t             status;
    logic [KEY_BITS-1:0] key;
    logic [63:0]         pay;
    logic [CNT_W-1:0]    count;
    logic                empty;
    logic                full;
  } outcome_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [79:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [95:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;

  keyed_stack_with_removal_top u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Behavioral stack: its own copy of the records and the occupancy.
  // Index 0 is the oldest record, depth_now-1 the top.
  // ---------------------------------------------------------------------------
  logic [KEY_BITS-1:0]     key_mem [DEPTH];
  logic [PAYLOAD_BITS-1:0] pay_mem [DEPTH];
  int                      depth_now = 0;

  function automatic outcome_t stack_apply(op_t op, logic [KEY_BITS-1:0] key,
                                           logic [63:0] pay);
    outcome_t r;
    int       hit;
    r        = '0;
    r.status = ST_OK;
    hit      = -1;
    case (op)
      OP_PUSH: begin
        if (depth_now >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          key_mem[depth_now] = key;
          pay_mem[depth_now] = pay[PAYLOAD_BITS-1:0];
          depth_now++;
        end
      end
      OP_POP: begin
        if (depth_now == 0) begin
          r.status = ST_EMPTY;
        end else begin
          depth_now--;
          r.key = key_mem[depth_now];
          r.pay = 64'(pay_mem[depth_now]);
        end
      end
      default: begin
        // oldest match wins on duplicate keys
        for (int i = 0; i < depth_now; i++)
          if (hit < 0 && key_mem[i] == key) hit = i;
        if (hit < 0) begin
          r.status = ST_MISS;
        end else begin
          r.key = key_mem[hit];
          r.pay = 64'(pay_mem[hit]);
          if (op == OP_REMOVE) begin
            // close the gap: later records slide down, old top slot goes stale
            for (int j = hit; j < depth_now - 1; j++) begin
              key_mem[j] = key_mem[j + 1];
              pay_mem[j] = pay_mem[j + 1];
            end
            depth_now--;
          end
        end
      end
    endcase
    r.count = CNT_W'(depth_now);
    r.empty = (depth_now == 0);
    r.full  = (depth_now == DEPTH);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Shared state between stimulus, driver and monitor
  // ---------------------------------------------------------------------------
  command_t cmd_q[$];        // items waiting to be driven
  outcome_t result_q[$];     // predicted results, oldest first
  command_t drv_cmd;
  logic     cmd_taken = 1'b0;
  int       snd_idle_pct = 0;
  int       rcv_idle_pct = 0;
  int       mismatches = 0;
  int       n_cmds = 0, n_results = 0;
  int       n_ok = 0, n_full = 0, n_empty = 0, n_miss = 0;
  int       peak_depth = 0;
  int       quiet_cycles = 0;

  // ---------------------------------------------------------------------------
  // Driver: inputs change on the falling edge. A new item is loaded only
  // once the current one has been taken (or nothing is on the bus).
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || cmd_taken) begin
      if (cmd_q.size() != 0 && $urandom_range(0, 99) >= snd_idle_pct) begin
        drv_cmd = cmd_q.pop_front();
        s_axis_tuser  <= drv_cmd.op;
        s_axis_tdata  <= {drv_cmd.pay, drv_cmd.key};
        s_axis_tvalid <= 1'b1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // receiver back-pressure
  always @(negedge clk) begin
    m_axis_tready <= ($urandom_range(0, 99) >= rcv_idle_pct);
  end

  // ---------------------------------------------------------------------------
  // Monitor: samples both streams on the rising edge. An accepted command is
  // run through the behavioral stack right away; an accepted result is
  // checked against the oldest prediction.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    outcome_t want;
    outcome_t got;
    cmd_taken <= s_axis_tvalid && s_axis_tready && !rst;
    if (!rst && s_axis_tvalid && s_axis_tready) begin
      want = stack_apply(op_t'(s_axis_tuser), s_axis_tdata[15:0], s_axis_tdata[79:16]);
      result_q.push_back(want);
      n_cmds++;
      if (depth_now > peak_depth) peak_depth = depth_now;
      case (want.status)
        ST_OK:    n_ok++;
        ST_FULL:  n_full++;
        ST_EMPTY: n_empty++;
        default:  n_miss++;
      endcase
    end
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.status = status_t'(m_axis_tuser);
      got.key    = m_axis_tdata[15:0];
      got.pay    = m_axis_tdata[79:16];
      got.count  = m_axis_tdata[86:80];
      got.empty  = m_axis_tdata[87];
      got.full   = m_axis_tdata[88];
      n_results++;
      if (result_q.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("%0t: result with nothing pending: st=%0d key=%h pay=%h cnt=%0d",
                   $realtime, got.status, got.key, got.pay, got.count);
      end else begin
        want = result_q.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= REPORT_MAX) begin
            $display("%0t: result %0d mismatch", $realtime, n_results);
            $display("  exp st=%0d key=%h pay=%h cnt=%0d e=%b f=%b",
                     want.status, want.key, want.pay, want.count, want.empty, want.full);
            $display("  got st=%0d key=%h pay=%h cnt=%0d e=%b f=%b",
                     got.status, got.key, got.pay, got.count, got.empty, got.full);
          end
        end
      end
    end
  end

  // watchdog: nothing moving on either stream for too long
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no progress, %0d results outstanding", $realtime, result_q.size());
      $display("tb failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  logic [KEY_BITS-1:0] key_pool [6];   // small key set so remove/query hit often

  task automatic add_cmd(op_t op, logic [KEY_BITS-1:0] key, logic [63:0] pay);
    command_t c;
    c.op  = op;
    c.key = key;
    c.pay = pay;
    cmd_q.push_back(c);
  endtask

  function automatic logic [KEY_BITS-1:0] pick_key();
    if ($urandom_range(0, 99) < 70) return key_pool[$urandom_range(0, 5)];
    return KEY_BITS'($urandom);
  endfunction

  function automatic logic [63:0] rand_payload();
    return {$urandom, $urandom};
  endfunction

  // Random items in stretches of push-heavy, mixed and drain-heavy traffic,
  // so the occupancy sweeps between empty and full. An optional opening
  // burst of pushes runs past DEPTH to hit the full-reject path.
  task automatic add_random_items(int total, bit fill_first);
    int  made;
    int  seg_left;
    int  push_pct;
    op_t op;
    made     = 0;
    seg_left = 0;
    push_pct = 50;
    if (fill_first) begin
      for (int i = 0; i < DEPTH + 6; i++) add_cmd(OP_PUSH, pick_key(), rand_payload());
      made = DEPTH + 6;
    end
    while (made < total) begin
      if (seg_left == 0) begin
        seg_left = $urandom_range(15, 40);
        case ($urandom_range(0, 2))
          0:       push_pct = 90;
          1:       push_pct = 45;
          default: push_pct = 10;
        endcase
      end
      if ($urandom_range(0, 99) < push_pct) begin
        op = OP_PUSH;
      end else begin
        case ($urandom_range(0, 2))
          0:       op = OP_POP;
          1:       op = OP_REMOVE;
          default: op = OP_QUERY;
        endcase
      end
      add_cmd(op, pick_key(), rand_payload());
      made++;
      seg_left--;
    end
  endtask

  // hold the sender until every queued item went in and every result came back
  task automatic wait_drained();
    do @(negedge clk);
    while (cmd_q.size() != 0 || s_axis_tvalid || result_q.size() != 0);
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    key_pool[0] = 16'h0000;
    key_pool[1] = 16'hFFFF;
    for (int i = 2; i < 6; i++) key_pool[i] = KEY_BITS'($urandom);

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: empty-stack corner cases, field extremes, duplicate keys,
    // remove from the bottom and top, then drain back to empty
    snd_idle_pct = 28;
    rcv_idle_pct = 49;
    add_cmd(OP_POP,    16'h1234, 64'h0);                 // pop on empty
    add_cmd(OP_QUERY,  16'h1234, 64'h0);                 // miss on empty
    add_cmd(OP_REMOVE, 16'h1234, 64'h0);                 // miss on empty
    add_cmd(OP_PUSH,   16'h0000, 64'h0);
    add_cmd(OP_PUSH,   16'hFFFF, 64'hFFFF_FFFF_FFFF_FFFF);
    add_cmd(OP_PUSH,   16'h00A5, 64'h1);
    add_cmd(OP_PUSH,   16'h0000, 64'h5555_5555_5555_5555); // duplicate key
    add_cmd(OP_PUSH,   16'h1234, 64'hAAAA_AAAA_AAAA_AAAA);
    add_cmd(OP_QUERY,  16'h0000, 64'h0);                 // oldest duplicate
    add_cmd(OP_QUERY,  16'hFFFF, 64'h0);
    add_cmd(OP_QUERY,  16'h7777, 64'h0);                 // miss on non-empty
    add_cmd(OP_REMOVE, 16'h0000, 64'h0);                 // bottom, full shift
    add_cmd(OP_QUERY,  16'h0000, 64'h0);                 // younger duplicate now
    add_cmd(OP_REMOVE, 16'h1234, 64'h0);                 // top, no shift
    add_cmd(OP_REMOVE, 16'hFFFF, 64'h0);
    add_cmd(OP_REMOVE, 16'hFFFF, 64'h0);                 // already gone
    add_cmd(OP_POP,    16'h0000, 64'h0);
    add_cmd(OP_POP,    16'h0000, 64'h0);
    add_cmd(OP_POP,    16'h0000, 64'h0);                 // empty again
    wait_drained();

    // random traffic in three idling regimes, with a full drain in between
    add_random_items(150, 1'b0);
    wait_drained();

    snd_idle_pct = 49;
    rcv_idle_pct = 28;
    add_random_items(150, 1'b1);
    wait_drained();

    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    add_random_items(150, 1'b1);
    wait_drained();

    // let any late result show up
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
    if (result_q.size() != 0) begin
      mismatches += result_q.size();
      $display("%0d results never arrived", result_q.size());
    end

    $display("Covered %0d commands: %0d ok, %0d full rejects, %0d empty pops, %0d misses.",
             n_cmds, n_ok, n_full, n_empty, n_miss);
    $display("Peak occupancy %0d of %0d; %0d results checked, %0d mismatches.",
             peak_depth, DEPTH, n_results, mismatches);
    if (mismatches == 0)
      $display("tb passed");
    else
      $display("tb failed");
    $finish;
  end

endmodule

[filelist.f]
+incdir+design
design/ksr_pkg.sv
design/ksr_ram.sv
design/ksr_engine.sv
design/keyed_stack_with_removal_top.sv
test/tb.sv
